/* rtl/core/lsfe_pkg.sv */
// Shared types, constants and line-code helpers for the LED strip frame encoder
`timescale 1ns / 1ps

package lsfe_pkg;

	// field widths
	localparam int IDX_W   = 16;
	localparam int COLOR_W = 8;
	localparam int RGB_W   = 3 * COLOR_W;
	localparam int CODE_W  = 3 * COLOR_W;
	localparam int REM_W   = 4;

	// frame layout
	localparam int BYTES_PER_LED = 9;

	// reciprocal of nine, ceil(2^19 / 9), exact quotient for any 16-bit offset
	localparam logic [IDX_W-1:0] DIV9_RECIP = 16'd58255;
	localparam int               DIV9_SHIFT = 19;

	// command codes
	localparam logic CMD_FILL = 1'b0;
	localparam logic CMD_READ = 1'b1;

	// status codes
	localparam logic ST_OK  = 1'b0;
	localparam logic ST_ERR = 1'b1;

	// spi line code of one color bit, sent msb first
	localparam logic [2:0] CODE_ONE  = 3'b110;
	localparam logic [2:0] CODE_ZERO = 3'b100;

	// color channel within one led, in frame order
	localparam logic [1:0] CH_GREEN = 2'd0;
	localparam logic [1:0] CH_RED   = 2'd1;
	localparam logic [1:0] CH_BLUE  = 2'd2;

	// byte within one 24-bit channel code, msb first
	localparam logic [1:0] PART_HI  = 2'd0;
	localparam logic [1:0] PART_MID = 2'd1;
	localparam logic [1:0] PART_LO  = 2'd2;

	typedef struct packed {
		logic [1:0] chan;
		logic [1:0] part;
	} byte_pos_t;

	// expand one intensity into its 24-bit line code
	function automatic logic [CODE_W-1:0] encode_byte(input logic [COLOR_W-1:0] v);
		logic [CODE_W-1:0] code;
		code = '0;
		for (int b = 0; b < COLOR_W; b++) begin
			code[3*b +: 3] = v[b] ? CODE_ONE : CODE_ZERO;
		end
		return code;
	endfunction

	// split a byte offset within one led into channel and code byte
	function automatic byte_pos_t rem_to_pos(input logic [REM_W-1:0] r);
		byte_pos_t p;
		unique case (r)
			4'd0:    p = '{chan: CH_GREEN, part: PART_HI};
			4'd1:    p = '{chan: CH_GREEN, part: PART_MID};
			4'd2:    p = '{chan: CH_GREEN, part: PART_LO};
			4'd3:    p = '{chan: CH_RED,   part: PART_HI};
			4'd4:    p = '{chan: CH_RED,   part: PART_MID};
			4'd5:    p = '{chan: CH_RED,   part: PART_LO};
			4'd6:    p = '{chan: CH_BLUE,  part: PART_HI};
			4'd7:    p = '{chan: CH_BLUE,  part: PART_MID};
			4'd8:    p = '{chan: CH_BLUE,  part: PART_LO};
			default: p = '{chan: CH_GREEN, part: PART_HI};
		endcase
		return p;
	endfunction

endpackage

/* rtl/core/lsfe_ram.sv */
// Generic single write port, single read port ram with registered read
`timescale 1ns / 1ps

module lsfe_ram #(
	parameter int WIDTH  = 24,
	parameter int DEPTH  = 64,
	parameter int ADDR_W = 6
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* rtl/core/led_strip_frame_encoder.sv */
// Top level: led color store with fill and encoded spi frame byte readout
// Fill: writes the leds from first_led to last_led, one led written a cycle.
// Read steps: bound check, offset, multiply by one ninth, store read, encode.
// Error results and byte 0 reads skip the later steps; a fill past the strip fails at the second range check.
// One request in flight; the next is taken once its result sits in the output register.
// After reset a clearing pass writes zero to every led, with in_stall high.
`timescale 1ns / 1ps

module led_strip_frame_encoder #(
	parameter int LED_COUNT = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          cmd,
	input  logic [lsfe_pkg::IDX_W-1:0]    first_led,
	input  logic [lsfe_pkg::IDX_W-1:0]    last_led,
	input  logic [lsfe_pkg::COLOR_W-1:0]  red,
	input  logic [lsfe_pkg::COLOR_W-1:0]  green,
	input  logic [lsfe_pkg::COLOR_W-1:0]  blue,
	input  logic [lsfe_pkg::IDX_W-1:0]    byte_index,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          status,
	output logic [lsfe_pkg::COLOR_W-1:0]  frame_byte
);

	localparam int AW = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
	localparam int FRAME_LEN = 1 + lsfe_pkg::BYTES_PER_LED * LED_COUNT;
	localparam int IW = lsfe_pkg::IDX_W;

	typedef enum logic [3:0] {
		S_CLR,
		S_IDLE,
		S_FCHK1,
		S_FCHK2,
		S_FILL,
		S_RCHK,
		S_RDEC,
		S_MUL,
		S_RADDR,
		S_ENC,
		S_DONE
	} state_t;

	state_t state_q;

	// captured request
	logic [IW-1:0]                first_q;
	logic [IW-1:0]                last_q;
	logic [lsfe_pkg::RGB_W-1:0]   color_q;
	logic [IW-1:0]                idx_q;

	// sequencer working registers
	logic [IW-1:0]                cur_q;
	logic [IW-1:0]                quo_q;
	logic [lsfe_pkg::REM_W-1:0]   rem_q;

	// pending and delivered result
	logic                         res_status_q;
	logic [lsfe_pkg::COLOR_W-1:0] res_byte_q;
	logic                         out_valid_q;
	logic                         status_q;
	logic [lsfe_pkg::COLOR_W-1:0] frame_byte_q;

	// shared subtractor
	logic [IW-1:0] alu_a;
	logic [IW-1:0] alu_b;
	logic [IW:0]   alu_diff;
	logic          alu_borrow;
	logic          alu_zero;

	// reciprocal multiply for the divide by nine
	logic [2*IW-1:0] mul_prod;

	// color store ports
	logic                       ram_we;
	logic [AW-1:0]              ram_waddr;
	logic [lsfe_pkg::RGB_W-1:0] ram_wdata;
	logic                       ram_re;
	logic [lsfe_pkg::RGB_W-1:0] ram_rdata;

	// readout path
	lsfe_pkg::byte_pos_t          pos;
	logic [lsfe_pkg::COLOR_W-1:0] chan_val;
	logic [lsfe_pkg::CODE_W-1:0]  chan_code;
	logic [lsfe_pkg::COLOR_W-1:0] code_byte;

	logic in_accept;
	logic out_free;

	assign in_stall  = (state_q != S_IDLE);
	assign in_accept = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;

	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign frame_byte = frame_byte_q;

	// operand select for the shared subtractor
	always_comb begin
		alu_a = '0;
		alu_b = '0;
		unique case (state_q)
			S_CLR: begin
				alu_a = cur_q;
				alu_b = IW'(LED_COUNT - 1);
			end
			S_FCHK1: begin
				alu_a = last_q;
				alu_b = first_q;
			end
			S_FCHK2: begin
				alu_a = last_q;
				alu_b = IW'(LED_COUNT);
			end
			S_FILL: begin
				alu_a = cur_q;
				alu_b = last_q;
			end
			S_RCHK: begin
				alu_a = idx_q;
				alu_b = IW'(FRAME_LEN);
			end
			S_RDEC: begin
				alu_a = idx_q;
				alu_b = IW'(1);
			end
			// remainder: offset minus nine times the quotient
			S_RADDR: begin
				alu_a = cur_q;
				alu_b = (quo_q << 3) + quo_q;
			end
			S_IDLE, S_MUL, S_ENC, S_DONE: begin
				alu_a = '0;
				alu_b = '0;
			end
			default: begin
				alu_a = '0;
				alu_b = '0;
			end
		endcase
	end

	assign alu_diff   = {1'b0, alu_a} - {1'b0, alu_b};
	assign alu_borrow = alu_diff[IW];
	assign alu_zero   = (alu_diff[IW-1:0] == '0);

	// offset times the reciprocal of nine
	assign mul_prod = {{IW{1'b0}}, cur_q} * {{IW{1'b0}}, lsfe_pkg::DIV9_RECIP};

	// color store control
	assign ram_we    = (state_q == S_CLR) || (state_q == S_FILL);
	assign ram_waddr = cur_q[AW-1:0];
	assign ram_wdata = (state_q == S_FILL) ? color_q : '0;
	assign ram_re    = (state_q == S_RADDR);

	lsfe_ram #(
		.WIDTH  (lsfe_pkg::RGB_W),
		.DEPTH  (LED_COUNT),
		.ADDR_W (AW)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (quo_q[AW-1:0]),
		.rdata (ram_rdata)
	);

	// channel pick and line code byte select
	always_comb begin
		pos = lsfe_pkg::rem_to_pos(rem_q);
		unique case (pos.chan)
			lsfe_pkg::CH_GREEN: chan_val = ram_rdata[23:16];
			lsfe_pkg::CH_RED:   chan_val = ram_rdata[15:8];
			lsfe_pkg::CH_BLUE:  chan_val = ram_rdata[7:0];
			default:            chan_val = '0;
		endcase
		chan_code = lsfe_pkg::encode_byte(chan_val);
		unique case (pos.part)
			lsfe_pkg::PART_HI:  code_byte = chan_code[23:16];
			lsfe_pkg::PART_MID: code_byte = chan_code[15:8];
			lsfe_pkg::PART_LO:  code_byte = chan_code[7:0];
			default:            code_byte = '0;
		endcase
	end

	// request capture (payload, no reset)
	always_ff @(posedge clk) begin
		if (in_accept) begin
			first_q <= first_led;
			last_q  <= last_led;
			color_q <= {green, red, blue};
			idx_q   <= byte_index;
		end
	end

	// sequencer and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLR;
			cur_q        <= '0;
			out_valid_q  <= 1'b0;
			quo_q        <= '0;
			rem_q        <= '0;
			res_status_q <= lsfe_pkg::ST_OK;
			res_byte_q   <= '0;
			status_q     <= lsfe_pkg::ST_OK;
			frame_byte_q <= '0;
		end else begin
			if (out_valid_q && !out_stall && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				// zero every led after reset
				S_CLR: begin
					if (alu_zero) begin
						state_q <= S_IDLE;
					end else begin
						cur_q <= cur_q + IW'(1);
					end
				end
				S_IDLE: begin
					if (in_accept) begin
						state_q <= (cmd == lsfe_pkg::CMD_FILL) ? S_FCHK1 : S_RCHK;
					end
				end
				// reversed range check
				S_FCHK1: begin
					if (alu_borrow) begin
						res_status_q <= lsfe_pkg::ST_ERR;
						res_byte_q   <= '0;
						state_q      <= S_DONE;
					end else begin
						state_q <= S_FCHK2;
					end
				end
				// range past the strip check
				S_FCHK2: begin
					if (!alu_borrow) begin
						res_status_q <= lsfe_pkg::ST_ERR;
						res_byte_q   <= '0;
						state_q      <= S_DONE;
					end else begin
						cur_q   <= first_q;
						state_q <= S_FILL;
					end
				end
				// one led written per cycle
				S_FILL: begin
					if (alu_zero) begin
						res_status_q <= lsfe_pkg::ST_OK;
						res_byte_q   <= '0;
						state_q      <= S_DONE;
					end else begin
						cur_q <= cur_q + IW'(1);
					end
				end
				// frame bound and leading zero byte
				S_RCHK: begin
					if (!alu_borrow) begin
						res_status_q <= lsfe_pkg::ST_ERR;
						res_byte_q   <= '0;
						state_q      <= S_DONE;
					end else if (idx_q == '0) begin
						res_status_q <= lsfe_pkg::ST_OK;
						res_byte_q   <= '0;
						state_q      <= S_DONE;
					end else begin
						state_q <= S_RDEC;
					end
				end
				// drop the leading byte, keep the offset
				S_RDEC: begin
					cur_q   <= alu_diff[IW-1:0];
					state_q <= S_MUL;
				end
				// led index from the reciprocal product
				S_MUL: begin
					quo_q   <= IW'(mul_prod[2*IW-1:lsfe_pkg::DIV9_SHIFT]);
					state_q <= S_RADDR;
				end
				// store read issued, byte offset within the led
				S_RADDR: begin
					rem_q   <= alu_diff[lsfe_pkg::REM_W-1:0];
					state_q <= S_ENC;
				end
				S_ENC: begin
					res_status_q <= lsfe_pkg::ST_OK;
					res_byte_q   <= code_byte;
					state_q      <= S_DONE;
				end
				// hand the result to the output register
				S_DONE: begin
					if (out_free) begin
						out_valid_q  <= 1'b1;
						status_q     <= res_status_q;
						frame_byte_q <= res_byte_q;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	// the store is written only by the clearing pass and by fills
	assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == S_CLR || state_q == S_FILL))
		else $error("color store written outside clear or fill");

	// fill walk stays inside the strip
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FILL) |-> (cur_q < IW'(LED_COUNT)))
		else $error("fill index past the strip");

	// quotient addresses a real led and the remainder stays below nine
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ENC) |-> (quo_q < IW'(LED_COUNT) && rem_q < 4'd9))
		else $error("read address out of range");

	// an error result never carries a frame byte
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && status_q == lsfe_pkg::ST_ERR) |-> (frame_byte_q == '0))
		else $error("error result with nonzero byte");
`endif

endmodule
